// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and codes for the text console character writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int CELL_W  = 16;
    localparam int INDEX_W = 11;
    localparam int POS_W   = 11;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [7:0] CODE_BACKSPACE = 8'h08;
    localparam logic [7:0] CODE_TAB       = 8'h09;
    localparam logic [7:0] CODE_NEWLINE   = 8'h0A;
    localparam logic [7:0] CODE_SPACE     = 8'h20;

    localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_FILL,
        S_COPY,
        S_CPWB,
        S_BSCAN,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/tcw_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Simple dual-port cell store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [tcw_pkg::CELL_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [tcw_pkg::CELL_W-1:0] o_rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/text_console_char_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text-mode console engine: cell store, cursor and put/read/clear sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: s_axis_tuser carries the mode (put, read, clear), and
//   s_axis_tdata carries char_code, attribute and cell_index. Master stream
//   returns one word per accepted word: cursor position, cell data, scrolled.
//   Write i_cfg_wdata with i_cfg_we to set the blanking cell value.
// Sequencing (one word in flight at a time):
//   ordinary character, newline, read, unused mode: straight to the result
//   backspace with column above zero or at home: straight to the result
//   tab: blanks its cells first; backspace across a row: scans the row above
//   scroll: copies each row but the top one row up, then blanks the bottom row
//   clear: blanks every cell of the store
//   The single write port of the cell store means that cells are moved or
//   blanked one at a time.
// Reset: the cursor goes home and a clearing pass over all ROWS*COLUMNS cells
//   (2000 by default) blanks the store; s_axis_tready stays low until it ends.
// Stall: a finished word waits in the output register; the next input word
//   is still taken and worked on, and its result waits for the register.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: blank_cell
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // char_code[7:0], attribute[15:8],
                                            // cell_index[26:16], zero fill
    input  wire logic [1:0]  s_axis_tuser,  // mode[1:0]
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // cursor_position[10:0],
                                            // cell_data[26:11], scrolled[27],
                                            // zero fill
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int AW     = $clog2(CELLS);
    localparam int CW     = $clog2(CELLS + 1);
    localparam int RW     = $clog2(ROWS);
    localparam int CLW    = $clog2(COLUMNS);
    localparam int SW     = CLW + 5;
    localparam int EW     = AW + INDEX_W;

    localparam logic [AW-1:0]  COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0]  COPY_LAST = AW'((ROWS - 1) * COLUMNS - 1);
    localparam logic [AW-1:0]  BOTTOM    = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0]  CELL_LAST = AW'(CELLS - 1);
    localparam logic [CW-1:0]  CNT_ALL   = CW'(CELLS);
    localparam logic [CW-1:0]  CNT_ROW   = CW'(COLUMNS);
    localparam logic [EW-1:0]  CELLS_E   = EW'(CELLS);
    localparam logic [SW-1:0]  COLS_S    = SW'(COLUMNS);
    localparam logic [SW-1:0]  TAB_S     = SW'(TAB_WIDTH);
    localparam logic [RW-1:0]  LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CLW-1:0] LAST_COL  = CLW'(COLUMNS - 1);

    // ---------------- registers ----------------
    t_state            r_state, n_state;
    logic [RW-1:0]     r_row, n_row;
    logic [CLW-1:0]    r_col, n_col;
    logic [AW-1:0]     r_addr, n_addr;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_scr_pend, n_scr_pend;
    logic              r_scrolled, n_scrolled;
    logic              r_rd_hit, n_rd_hit;
    logic              r_cp_valid, n_cp_valid;
    logic [AW-1:0]     r_cp_addr, n_cp_addr;
    logic [CELL_W-1:0] r_blank;
    logic              r_out_valid, n_out_valid;
    logic [POS_W-1:0]  r_out_pos, n_out_pos;
    logic [CELL_W-1:0] r_out_data, n_out_data;
    logic              r_out_scr, n_out_scr;

    // ---------------- cell store port ----------------
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata, mem_rdata;

    tcw_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // ---------------- input decode ----------------
    logic [1:0]     in_mode;
    logic [7:0]     in_code, in_attr;
    logic [INDEX_W-1:0] in_idx;
    logic           acc;
    logic           is_put, is_nl, is_tab, is_bs, is_chr;
    logic [AW-1:0]  lin, lin_m1;
    logic [EW-1:0]  idx_ext, pos_ext;
    logic           rd_hit;
    logic [SW-1:0]  col_s, tab_sum, tab_next, tab_cnt, col_p1;
    logic           wrap, scroll_need, bs_scan, bs_stop, out_free;

    assign in_mode = s_axis_tuser;
    assign in_code = s_axis_tdata[7:0];
    assign in_attr = s_axis_tdata[15:8];
    assign in_idx  = s_axis_tdata[26:16];

    assign s_axis_tready = (r_state == S_IDLE);
    assign acc           = s_axis_tvalid && s_axis_tready;

    assign is_put = (in_mode == MODE_PUT);
    assign is_nl  = (in_code == CODE_NEWLINE);
    assign is_tab = (in_code == CODE_TAB);
    assign is_bs  = (in_code == CODE_BACKSPACE);
    assign is_chr = !is_nl && !is_tab && !is_bs;

    // linear cursor address; the row and column always stay on the screen
    assign lin    = AW'(r_row) * COLS_A + AW'(r_col);
    assign lin_m1 = lin - AW'(1);

    assign idx_ext = {{AW{1'b0}}, in_idx};
    assign rd_hit  = (idx_ext < CELLS_E);
    assign pos_ext = {{INDEX_W{1'b0}}, lin};

    assign col_s    = SW'(r_col);
    assign tab_sum  = col_s + TAB_S;
    assign tab_next = (tab_sum > COLS_S) ? COLS_S : tab_sum;
    assign tab_cnt  = tab_next - col_s;
    assign col_p1   = col_s + SW'(1);

    assign wrap        = is_nl || (is_tab && (tab_next == COLS_S))
                      || (is_chr && (col_p1 == COLS_S));
    assign scroll_need = wrap && (r_row == LAST_ROW);
    assign bs_scan     = is_bs && (r_col == '0) && (r_row != '0);
    assign bs_stop     = (r_col == '0) || (mem_rdata[7:0] != CODE_SPACE);
    assign out_free    = !r_out_valid || m_axis_tready;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_addr == CELL_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    if (in_mode == MODE_CLEAR) begin
                        n_state = S_FILL;
                    end else if (!is_put) begin
                        n_state = S_FIN;
                    end else if (is_tab) begin
                        n_state = S_FILL;
                    end else if (bs_scan) begin
                        n_state = S_BSCAN;
                    end else if (scroll_need) begin
                        n_state = S_COPY;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FILL: begin
                if (r_cnt == CW'(1)) begin
                    n_state = r_scr_pend ? S_COPY : S_FIN;
                end
            end
            S_COPY: begin
                if (r_addr == COPY_LAST) begin
                    n_state = S_CPWB;
                end
            end
            S_CPWB: begin
                n_state = S_FILL;
            end
            S_BSCAN: begin
                if (bs_stop) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // ---------------- datapath and store control ----------------
    always_comb begin
        n_row       = r_row;
        n_col       = r_col;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_scr_pend  = r_scr_pend;
        n_scrolled  = r_scrolled;
        n_rd_hit    = r_rd_hit;
        n_cp_valid  = 1'b0;
        n_cp_addr   = r_cp_addr;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_pos   = r_out_pos;
        n_out_data  = r_out_data;
        n_out_scr   = r_out_scr;
        mem_we      = 1'b0;
        mem_waddr   = lin;
        mem_wdata   = r_blank;
        mem_re      = 1'b0;
        mem_raddr   = lin_m1;

        case (r_state)
            S_INIT: begin
                // blank with the reset value; later register writes do not apply
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = BLANK_RESET;
                n_addr    = r_addr + AW'(1);
            end
            S_IDLE: begin
                if (acc) begin
                    n_scrolled = is_put && scroll_need;
                    n_rd_hit   = (in_mode == MODE_READ) && rd_hit;
                    n_scr_pend = 1'b0;
                    n_addr     = '0;
                    n_cnt      = CNT_ALL;
                    if (in_mode == MODE_READ) begin
                        mem_re    = rd_hit;
                        mem_raddr = idx_ext[AW-1:0];
                    end
                    if (is_put) begin
                        if (is_tab) begin
                            // blank from the old column onward; the cursor advances on acceptance
                            n_addr     = lin;
                            n_cnt      = CW'(tab_cnt);
                            n_scr_pend = scroll_need;
                            n_col      = wrap ? '0 : tab_next[CLW-1:0];
                        end else if (is_bs) begin
                            if (r_col != '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = lin_m1;
                                n_col     = r_col - CLW'(1);
                            end else if (r_row != '0) begin
                                // go up one row and start the scan at its end
                                mem_re = 1'b1;
                                n_row  = r_row - RW'(1);
                                n_col  = LAST_COL;
                            end else begin
                                mem_we = 1'b1;
                            end
                        end else if (is_nl) begin
                            n_col = '0;
                        end else begin
                            mem_we    = 1'b1;
                            mem_wdata = {in_attr, in_code};
                            n_col     = wrap ? '0 : col_p1[CLW-1:0];
                        end
                        if (wrap && !scroll_need) begin
                            n_row = r_row + RW'(1);
                        end
                    end
                end
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                n_addr    = r_addr + AW'(1);
                n_cnt     = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_addr     = '0;
                    n_scr_pend = 1'b0;
                end
            end
            S_COPY: begin
                // read one row down, write it back in the next cycle
                mem_re     = 1'b1;
                mem_raddr  = r_addr + COLS_A;
                mem_we     = r_cp_valid;
                mem_waddr  = r_cp_addr;
                mem_wdata  = mem_rdata;
                n_cp_valid = 1'b1;
                n_cp_addr  = r_addr;
                n_addr     = r_addr + AW'(1);
            end
            S_CPWB: begin
                mem_we    = r_cp_valid;
                mem_waddr = r_cp_addr;
                mem_wdata = mem_rdata;
                n_addr    = BOTTOM;
                n_cnt     = CNT_ROW;
            end
            S_BSCAN: begin
                if (bs_stop) begin
                    mem_we = 1'b1;
                end else begin
                    mem_re = 1'b1;
                    n_col  = r_col - CLW'(1);
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = pos_ext[POS_W-1:0];
                    n_out_data  = r_rd_hit ? mem_rdata : '0;
                    n_out_scr   = r_scrolled;
                end
            end
            default: begin
                n_addr = '0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_addr      <= '0;
            r_scr_pend  <= 1'b0;
            r_cp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_blank     <= BLANK_RESET;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_addr      <= n_addr;
            r_scr_pend  <= n_scr_pend;
            r_cp_valid  <= n_cp_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_blank <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_scrolled <= n_scrolled;
        r_rd_hit   <= n_rd_hit;
        r_cp_addr  <= n_cp_addr;
        r_out_pos  <= n_out_pos;
        r_out_data <= n_out_data;
        r_out_scr  <= n_out_scr;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_scr, r_out_data, r_out_pos};

endmodule

`default_nettype wire

// ===== rtl/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console character writer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam logic [POS_W:0] CELLS_P  = (POS_W + 1)'(CELLS);
    localparam logic [POS_W:0] BOTTOM_P = (POS_W + 1)'((ROWS - 1) * COLUMNS);
    localparam logic           BIG      = (CELLS > 2047);

    logic [POS_W:0] pos;
    assign pos = {1'b0, m_axis_tdata[POS_W-1:0]};

    // out of reset: no result and the clearing pass holds off input
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (!m_axis_tvalid && !s_axis_tready))
        else $error("output valid or input ready right after reset");

    // one word in flight at a time: input is never taken back to back
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    // the cursor never leaves the screen
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (BIG || (pos < CELLS_P)))
        else $error("cursor position beyond the screen");

    // a scroll leaves the cursor on the bottom row
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[27]) |-> (BIG || (pos >= BOTTOM_P)))
        else $error("scrolled with cursor above the bottom row");

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

endmodule

bind text_console_char_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/text_console_char_writer_checker.sv =====
// ----------------------------------------------------------------------------
// text_console_char_writer_checker
// Watches both streams and the blank register port of the console writer. It
// keeps its own screen, cursor and blank value, and works out the word that
// each accepted input word must return. It then compares every returned word
// with the oldest one still due.
// ----------------------------------------------------------------------------
module text_console_char_writer_checker #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // char_code[7:0], attribute[15:8],
                                        // cell_index[26:16], zero fill
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // cursor_position[10:0],
                                        // cell_data[26:11], scrolled[27]
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } t_console_word;

    logic [CELL_W-1:0] screen [CELLS];
    logic [CELL_W-1:0] blank_value;
    int                cursor_row;
    int                cursor_col;
    t_console_word     results_due [$];

    function automatic void blank_cells(input int start, input int count);
        for (int i = 0; i < count && start + i < CELLS; i++) begin
            screen[start + i] = blank_value;
        end
    endfunction

    function automatic void scroll_screen();
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
            screen[i] = screen[i + COLUMNS];
        end
        blank_cells((ROWS - 1) * COLUMNS, COLUMNS);
    endfunction

    // Returns 1 when the put scrolled the screen.
    function automatic logic put_character(input logic [7:0] code, input logic [7:0] attr);
        int next_col;
        int at;
        if (code == CODE_NEWLINE) begin
            cursor_row++;
            cursor_col = 0;
        end else if (code == CODE_TAB) begin
            next_col = cursor_col + TAB_WIDTH;
            if (next_col > COLUMNS) next_col = COLUMNS;
            blank_cells(cursor_row * COLUMNS + cursor_col, next_col - cursor_col);
            cursor_col = next_col;
        end else if (code == CODE_BACKSPACE) begin
            if (cursor_col > 0) begin
                cursor_col--;
            end else if (cursor_row > 0) begin
                cursor_row--;
                cursor_col = COLUMNS - 1;
                while (cursor_col > 0 &&
                       screen[cursor_row * COLUMNS + cursor_col][7:0] == CODE_SPACE) begin
                    cursor_col--;
                end
            end
            blank_cells(cursor_row * COLUMNS + cursor_col, 1);
        end else begin
            at = cursor_row * COLUMNS + cursor_col;
            if (at < CELLS) screen[at] = {attr, code};
            cursor_col++;
        end

        if (cursor_col >= COLUMNS) begin
            cursor_col = 0;
            cursor_row++;
        end
        if (cursor_row >= ROWS) begin
            scroll_screen();
            cursor_row = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_console_word apply_console_word(input logic [1:0] mode,
                                                         input logic [7:0] code,
                                                         input logic [7:0] attr,
                                                         input logic [INDEX_W-1:0] index);
        t_console_word w;
        w = '0;
        case (mode)
            MODE_PUT:   w.scrolled = put_character(code, attr);
            MODE_READ:  if (index < CELLS) w.cell_data = screen[index];
            MODE_CLEAR: blank_cells(0, CELLS);
            default:    ;
        endcase
        w.position = POS_W'(cursor_row * COLUMNS + cursor_col);
        return w;
    endfunction

    function automatic void reset_console();
        blank_value = BLANK_RESET;
        blank_cells(0, CELLS);
        cursor_row = 0;
        cursor_col = 0;
    endfunction

    always @(posedge i_clk) begin
        t_console_word got;
        t_console_word want;
        if (!i_rst_n) begin
            reset_console();
            results_due.delete();
        end else begin
            // Check the outgoing word before predicting the incoming one.
            if (m_axis_tvalid && m_axis_tready) begin
                got.position  = m_axis_tdata[10:0];
                got.cell_data = m_axis_tdata[26:11];
                got.scrolled  = m_axis_tdata[27];
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got %h", $time,
                             m_axis_tdata);
                    o_errors++;
                end else begin
                    want = results_due.pop_front();
                    if (got.position !== want.position) begin
                        $display("%0t: cursor_position expected %0d, got %0d", $time,
                                 want.position, got.position);
                        o_errors++;
                    end
                    if (got.cell_data !== want.cell_data) begin
                        $display("%0t: cell_data expected %h, got %h", $time,
                                 want.cell_data, got.cell_data);
                        o_errors++;
                    end
                    if (got.scrolled !== want.scrolled) begin
                        $display("%0t: scrolled expected %0b, got %0b", $time,
                                 want.scrolled, got.scrolled);
                        o_errors++;
                    end
                end
            end
            if (i_cfg_we) blank_value = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                results_due.push_back(apply_console_word(s_axis_tuser, s_axis_tdata[7:0],
                                                         s_axis_tdata[15:8],
                                                         s_axis_tdata[26:16]));
            end
        end
        o_pending = results_due.size();
    end

endmodule

// ===== tb/tb_text_console_char_writer.sv =====
// ----------------------------------------------------------------------------
// tb_text_console_char_writer
// Drives the console writer with a short directed sequence (cell reads at the
// ends and past the end of the screen, extreme characters and attributes,
// tab, newline, backspace at home and across a row, the unused mode, clear)
// and then with weighted random put/read/clear traffic over several blank
// cell values. A checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_text_console_char_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int         COLUMNS         = 80;
    localparam int         ROWS            = 25;
    localparam int         TAB_WIDTH       = 4;
    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam int         PHASES          = 6;
    localparam int         WORDS_PER_PHASE = 300;
    // Time limit, several times as long as a run in which every word scrolls.
    localparam longint     LIMIT_NS        = 200_000_000;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [15:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;  // char_code[7:0], attribute[15:8],
                                      // cell_index[26:16], zero fill
    logic [1:0]  s_axis_tuser  = '0;  // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // cursor_position[10:0], cell_data[26:11],
                                      // scrolled[27], zero fill

    int errors;
    int pending;
    int send_idle_pct = 9;
    int recv_idle_pct = 52;
    int words_sent;

    text_console_char_writer #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    text_console_char_writer_checker #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or drops a word.
    initial begin
        #(LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: stall at random, at the rate of the current phase.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Present one word and hold it until the block takes it. Call at a falling
    // edge; returns at a falling edge with tvalid still high, so back-to-back
    // words drop tvalid in between only when a random idle gap is taken.
    task automatic send_word(input logic [1:0] mode, input logic [7:0] code,
                             input logic [7:0] attr, input logic [10:0] index);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {5'b0, index, attr, code};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        words_sent++;
    endtask

    // Drop tvalid and wait until every word due has come back.
    task automatic drain_console();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Write the blank cell register; only call while the block is drained.
    task automatic write_blank(input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Weighted mix: mostly printable puts so rows fill and the screen scrolls,
    // plenty of reads to look back at what was written, a newline followed by
    // a backspace to exercise the scan across a row, and rare clears.
    task automatic send_random_word();
        int          pick;
        logic [7:0]  code;
        logic [10:0] read_at;
        pick    = $urandom_range(0, 99);
        code    = ($urandom_range(0, 4) == 0) ? CODE_SPACE : 8'($urandom_range(0, 255));
        read_at = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(2000, 2047))
                                              : 11'($urandom_range(0, 1999));
        if (pick < 55) begin
            send_word(MODE_PUT, code, 8'($urandom), 11'($urandom));
        end else if (pick < 60) begin
            send_word(MODE_PUT, CODE_TAB, 8'($urandom), 11'($urandom));
        end else if (pick < 62) begin
            send_word(MODE_PUT, CODE_NEWLINE, 8'($urandom), 11'($urandom));
        end else if (pick < 67) begin
            send_word(MODE_PUT, CODE_BACKSPACE, 8'($urandom), 11'($urandom));
        end else if (pick < 70) begin
            send_word(MODE_PUT, CODE_NEWLINE, 8'($urandom), 11'($urandom));
            send_word(MODE_PUT, CODE_BACKSPACE, 8'($urandom), 11'($urandom));
        end else if (pick < 97) begin
            send_word(MODE_READ, 8'($urandom), 8'($urandom), read_at);
        end else if (pick < 98) begin
            send_word(MODE_CLEAR, 8'($urandom), 8'($urandom), 11'($urandom));
        end else begin
            send_word(MODE_UNUSED, 8'($urandom), 8'($urandom), 11'($urandom));
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words, default blank value. The first one also waits out
        // the clearing pass after reset, since tready stays low until it ends.
        send_word(MODE_READ, 8'h00, 8'h00, 11'd0);
        send_word(MODE_READ, 8'hFF, 8'hFF, 11'd1999);
        send_word(MODE_READ, 8'h00, 8'h00, 11'd2000);      // just past the screen
        send_word(MODE_READ, 8'h00, 8'h00, 11'd2047);      // top of the index range
        send_word(MODE_PUT, CODE_BACKSPACE, 8'h00, 11'd0); // backspace at home
        send_word(MODE_PUT, 8'hFF, 8'hFF, 11'h7FF);
        send_word(MODE_PUT, 8'h00, 8'h00, 11'd0);
        send_word(MODE_PUT, 8'h41, 8'h1E, 11'd0);
        send_word(MODE_PUT, CODE_TAB, 8'h00, 11'd0);
        send_word(MODE_READ, 8'h00, 8'h00, 11'd0);
        send_word(MODE_READ, 8'h00, 8'h00, 11'd2);
        send_word(MODE_PUT, CODE_BACKSPACE, 8'h00, 11'd0);
        send_word(MODE_PUT, CODE_NEWLINE, 8'h00, 11'd0);
        send_word(MODE_PUT, CODE_BACKSPACE, 8'h00, 11'd0); // scan back over spaces
        send_word(MODE_READ, 8'h00, 8'h00, 11'd3);
        send_word(MODE_UNUSED, 8'hA5, 8'h5A, 11'h555);
        send_word(MODE_CLEAR, 8'h00, 8'h00, 11'd0);
        send_word(MODE_READ, 8'h00, 8'h00, 11'd1);
        send_word(MODE_PUT, 8'h5A, 8'h80, 11'd0);
        send_word(MODE_READ, 8'h00, 8'h00, 11'd3);
        drain_console();

        // Random phases: sender idles lightly first, then the receiver does,
        // then run flat out. Change the blank value between phases, extremes
        // included, and once to a space with a non-default attribute.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 2) begin
                send_idle_pct = 9;
                recv_idle_pct = 52;
            end else if (phase < 4) begin
                send_idle_pct = 52;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                1:       write_blank(16'hFFFF);
                2:       write_blank(16'h0000);
                4:       write_blank({8'h1F, CODE_SPACE});
                3, 5:    write_blank(16'($urandom));
                default: ;
            endcase
            words_sent = 0;
            while (words_sent < WORDS_PER_PHASE) send_random_word();
            drain_console();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== text_console_char_writer.f =====
rtl/tcw_pkg.sv
rtl/tcw_cell_ram.sv
rtl/text_console_char_writer.sv
rtl/tcw_checker.sv
tb/text_console_char_writer_checker.sv
tb/tb_text_console_char_writer.sv
